// File: hdl/dsa_pkg.sv
// types and constants shared by the descriptor slot allocator
`default_nettype none
package dsa_pkg;

  localparam int MODE_W   = 3;
  localparam int IDX_W    = 10;
  localparam int ARG_W    = 10;
  localparam int FH_W     = 16;
  localparam int STATUS_W = 2;
  localparam int CHUNK    = 16;
  localparam int CHUNK_W  = 4;

  typedef enum logic [MODE_W-1:0] {
    OP_ALLOC,
    OP_BIND,
    OP_RELEASE,
    OP_LOOKUP,
    OP_INSTALL,
    OP_GET_FLAG,
    OP_SET_FLAG,
    OP_DUP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK,
    STAT_BAD_DESC,
    STAT_NO_SLOT
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [ARG_W-1:0] arg;
    logic [FH_W-1:0]  fh;
    logic             ce;
    logic             ok_idx;
    logic             scan;
  } req_t;

endpackage
`default_nettype wire

// File: hdl/dsa_if.sv
// request and response channel interfaces
`default_nettype none
interface dsa_in_if import dsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [IDX_W-1:0]  slot_index;
  logic [ARG_W-1:0]  argument;
  logic [FH_W-1:0]   file_handle;
  logic              cloexec;

  modport source (output valid, mode, slot_index, argument, file_handle, cloexec,
                  input ready);
  modport sink (input valid, mode, slot_index, argument, file_handle, cloexec,
                output ready);
endinterface

interface dsa_out_if import dsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    result_slot;
  logic [FH_W-1:0]     handle_out;
  logic                flag_out;

  modport source (output valid, status, result_slot, handle_out, flag_out,
                  input ready);
  modport sink (input valid, status, result_slot, handle_out, flag_out,
                output ready);
endinterface
`default_nettype wire

// File: hdl/dsa_front.sv
// request intake, classification and two-entry request queue
`default_nettype none
module dsa_front import dsa_pkg::*; #(
  parameter int SLOTS = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  dsa_in_if.sink    req,
  output logic      deq_valid,
  output req_t      deq,
  input  wire logic deq_pop
);

  req_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  req_t       incoming;
  op_t        op_in;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign deq_valid = (count != 2'd0);
  assign pop       = deq_pop && deq_valid;
  assign deq       = q_mem[rd_ptr];

  // classify: range check on the slot, and whether a free-slot scan may follow
  always_comb begin
    op_in           = op_t'(req.mode);
    incoming.op     = op_in;
    incoming.idx    = req.slot_index;
    incoming.arg    = req.argument;
    incoming.fh     = req.file_handle;
    incoming.ce     = req.cloexec;
    incoming.ok_idx = ({1'b0, req.slot_index} < (IDX_W + 1)'(SLOTS));
    incoming.scan   = op_in inside {OP_ALLOC, OP_DUP};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/dsa_back.sv
// slot table, chunked free-slot scan and response register
`default_nettype none
module dsa_back import dsa_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire req_t q,
  output logic      q_pop,
  dsa_out_if.source rsp
);

  localparam int IW  = $clog2(SLOTS);
  localparam int HW  = $clog2(SLOTS + 1);
  localparam int SW  = (HW > ARG_W) ? HW : ARG_W;
  localparam int NCH = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PAD = NCH * CHUNK;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t                 state;
  logic [SLOTS-1:0]       busy;
  logic [SLOTS-1:0]       bound;
  logic [HW-1:0]          hint;
  logic [HANDLE_BITS-1:0] handle_mem [SLOTS];
  logic                   flag_mem [SLOTS];
  logic [HANDLE_BITS-1:0] handle_rd;
  logic                   flag_rd;

  req_t          cur;
  logic          st_busy;
  logic          st_bound;
  logic [SW-1:0] start;
  logic          at_hint;
  logic [CW-1:0] chunk;
  logic          first;
  logic          found;
  logic [IW-1:0] n;

  logic [STATUS_W-1:0] rsp_status;
  logic [IDX_W-1:0]    rsp_slot;
  logic [FH_W-1:0]     rsp_handle;
  logic                rsp_flag;
  logic                rsp_valid;

  // dispatch side
  logic [IW-1:0] rd_addr;
  logic [SW-1:0] arg_w;
  logic [SW-1:0] hint_w;
  logic [SW-1:0] start_calc;
  logic          need_scan;

  // scan side
  logic [PAD-1:0]     busy_pad;
  logic [CHUNK-1:0]   window;
  logic [CHUNK-1:0]   mask;
  logic [CHUNK-1:0]   free_bits;
  logic [CHUNK_W-1:0] pos;
  logic               hit;
  logic [CW+CHUNK_W-1:0] hit_slot;

  // finish side
  logic                   fin_go;
  status_t                f_status;
  logic [IDX_W-1:0]       f_slot;
  logic [FH_W-1:0]        f_handle;
  logic                   f_flag;
  logic                   wr_en;
  logic                   wr_flag_only;
  logic [IW-1:0]          wr_addr;
  logic [HANDLE_BITS-1:0] wr_handle;
  logic                   wr_flag;
  logic                   mark_busy;
  logic                   mark_bound;
  logic                   clear_slot;
  logic                   hint_en;
  logic [HW-1:0]          hint_next;
  logic [IW-1:0]          cur_addr;
  logic [SW-1:0]          cur_idx_w;
  logic [31:0]            fh_w;
  logic [31:0]            hrd_w;
  logic                   reserved;

  assign q_pop = (state == S_IDLE) && q_valid;

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.result_slot = rsp_slot;
  assign rsp.handle_out  = rsp_handle;
  assign rsp.flag_out    = rsp_flag;

  // dispatch
  always_comb begin
    rd_addr    = q.ok_idx ? q.idx[IW-1:0] : '0;
    arg_w      = SW'(q.arg);
    hint_w     = SW'(hint);
    start_calc = (arg_w >= hint_w) ? arg_w : hint_w;
    need_scan  = q.scan && ((q.op == OP_ALLOC) || (q.ok_idx && bound[rd_addr]));
  end

  // scan one chunk of the occupancy map per cycle
  always_comb begin
    busy_pad            = '1;
    busy_pad[SLOTS-1:0] = busy;
    window              = busy_pad[chunk * CHUNK +: CHUNK];
    mask                = first ? ({CHUNK{1'b1}} << start[CHUNK_W-1:0]) : {CHUNK{1'b1}};
    free_bits           = ~window & mask;
    hit                 = |free_bits;
    pos                 = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        pos = CHUNK_W'(j);
      end
    end
    hit_slot = {chunk, pos};
  end

  // finish: decide result and table updates
  always_comb begin
    fin_go       = (state == S_FIN) && (!rsp_valid || rsp.ready);
    cur_addr     = cur.ok_idx ? cur.idx[IW-1:0] : '0;
    cur_idx_w    = SW'(cur.idx);
    fh_w         = 32'(cur.fh);
    hrd_w        = 32'(handle_rd);
    reserved     = st_busy && !st_bound;
    f_status     = STAT_OK;
    f_slot       = cur.idx;
    f_handle     = '0;
    f_flag       = 1'b0;
    wr_en        = 1'b0;
    wr_flag_only = 1'b0;
    wr_addr      = cur_addr;
    wr_handle    = fh_w[HANDLE_BITS-1:0];
    wr_flag      = cur.ce;
    mark_busy    = 1'b0;
    mark_bound   = 1'b0;
    clear_slot   = 1'b0;
    hint_en      = 1'b0;
    hint_next    = hint;
    case (cur.op)
      OP_ALLOC: begin
        if (found) begin
          f_slot    = IDX_W'(n);
          wr_addr   = n;
          mark_busy = 1'b1;
        end else begin
          f_status = STAT_NO_SLOT;
        end
        hint_en   = at_hint;
        hint_next = found ? (HW'(n) + HW'(1)) : HW'(SLOTS);
      end
      OP_BIND: begin
        if (!cur.ok_idx || !reserved) begin
          f_status = STAT_BAD_DESC;
        end else begin
          wr_en      = 1'b1;
          mark_bound = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (!cur.ok_idx || !st_busy) begin
          f_status = STAT_BAD_DESC;
        end else begin
          clear_slot = 1'b1;
          hint_en    = (cur_idx_w < SW'(hint));
          hint_next  = HW'(cur.idx);
        end
      end
      OP_LOOKUP: begin
        if (!cur.ok_idx || !st_bound) begin
          f_status = STAT_BAD_DESC;
        end else begin
          f_handle = hrd_w[FH_W-1:0];
        end
      end
      OP_INSTALL: begin
        if (!cur.ok_idx || reserved) begin
          f_status = STAT_BAD_DESC;
        end else begin
          wr_en      = 1'b1;
          mark_busy  = 1'b1;
          mark_bound = 1'b1;
          hint_en    = (cur_idx_w == SW'(hint));
          hint_next  = hint + HW'(1);
        end
      end
      OP_GET_FLAG: begin
        if (!cur.ok_idx || !st_bound) begin
          f_status = STAT_BAD_DESC;
        end else begin
          f_flag = flag_rd;
        end
      end
      OP_SET_FLAG: begin
        if (!cur.ok_idx || !st_bound) begin
          f_status = STAT_BAD_DESC;
        end else begin
          wr_flag_only = 1'b1;
          wr_flag      = cur.arg[0];
        end
      end
      OP_DUP: begin
        if (!cur.ok_idx || !st_bound) begin
          f_status = STAT_BAD_DESC;
        end else begin
          if (found) begin
            f_slot     = IDX_W'(n);
            wr_addr    = n;
            wr_handle  = handle_rd;
            wr_en      = 1'b1;
            mark_busy  = 1'b1;
            mark_bound = 1'b1;
          end else begin
            f_status = STAT_NO_SLOT;
          end
          hint_en   = at_hint;
          hint_next = found ? (HW'(n) + HW'(1)) : HW'(SLOTS);
        end
      end
      default: begin
        f_status = STAT_BAD_DESC;
      end
    endcase
  end

  // handle and flag stores
  always_ff @(posedge clk) begin
    if (q_pop) begin
      handle_rd <= handle_mem[rd_addr];
    end
    if (fin_go && wr_en) begin
      handle_mem[wr_addr] <= wr_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      flag_rd <= flag_mem[rd_addr];
    end
    if (fin_go && (wr_en || wr_flag_only)) begin
      flag_mem[wr_addr] <= wr_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      bound     <= '0;
      hint      <= '0;
      rsp_valid <= 1'b0;
      found     <= 1'b0;
      first     <= 1'b0;
      chunk     <= '0;
    end else begin
      if (rsp_valid && rsp.ready && !fin_go) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur      <= q;
            st_busy  <= busy[rd_addr];
            st_bound <= bound[rd_addr];
            start    <= start_calc;
            at_hint  <= (start_calc == hint_w);
            found    <= 1'b0;
            first    <= 1'b1;
            chunk    <= CW'(start_calc >> CHUNK_W);
            if (need_scan && (start_calc < SW'(SLOTS))) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          if (hit) begin
            found <= 1'b1;
            n     <= IW'(hit_slot);
            state <= S_FIN;
          end else if (chunk == CW'(NCH - 1)) begin
            state <= S_FIN;
          end else begin
            chunk <= chunk + CW'(1);
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (mark_busy) begin
              busy[wr_addr] <= 1'b1;
            end
            if (mark_bound) begin
              bound[wr_addr] <= 1'b1;
            end
            if (clear_slot) begin
              busy[cur_addr]  <= 1'b0;
              bound[cur_addr] <= 1'b0;
            end
            if (hint_en) begin
              hint <= hint_next;
            end
            rsp_status <= f_status;
            rsp_slot   <= f_slot;
            rsp_handle <= f_handle;
            rsp_flag   <= f_flag;
            rsp_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= HW'(SLOTS))
    else $error("free hint beyond table");

  a_bound_busy: assert property (@(posedge clk) disable iff (rst)
    (bound & ~busy) == '0)
    else $error("bound slot not marked in use");

  a_found_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && found |-> !busy[n])
    else $error("scan returned a slot in use");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("response raised outside finish");

endmodule
`default_nettype wire

// File: hdl/descriptor_slot_allocator_core.sv
// top level of the descriptor slot allocator
// A table of SLOTS descriptor slots, each free, reserved or bound to a file handle
// with a close-on-exec flag, served one request at a time in arrival order. A
// two-entry request queue sits in front of the executor, and a response register
// behind it, so a new request is taken while a response waits. Lookup, bind,
// release, install and flag operations go from idle straight to the finish state
// of the executor; alloc and duplicate first pass through a scan state that walks
// the occupancy map one 16-slot chunk at a time, from the larger of the minimum
// and the lowest-free hint; a minimum past the table or a duplicate of a slot
// that is not bound scans nothing. No clearing pass is needed after reset.
`default_nettype none
module descriptor_slot_allocator_core import dsa_pkg::*; #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  dsa_in_if.sink    req,
  dsa_out_if.source rsp
);

  logic deq_valid;
  req_t deq;
  logic deq_pop;

  dsa_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .deq_valid (deq_valid),
    .deq       (deq),
    .deq_pop   (deq_pop)
  );

  dsa_back #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (deq_valid),
    .q       (deq),
    .q_pop   (deq_pop),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

// File: dv/tb.sv
// testbench for the descriptor slot allocator core: table predictor, directed and random traffic
`timescale 1ns / 100ps
module tb import dsa_pkg::*; ();

  localparam int SLOTS = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_OPS = 780;
  localparam int QUIET_TAIL = 150;
  localparam bit [2:0] WANT_RESERVED = 3'b010;
  localparam bit [2:0] WANT_BOUND = 3'b100;
  localparam bit [2:0] WANT_IN_USE = 3'b110;

  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_RESERVED,
    SLOT_BOUND
  } slot_kind_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot;
    logic [FH_W-1:0]  handle;
    logic             flag;
  } outcome_t;

  logic clk;
  logic rst;

  dsa_in_if  req_bus ();
  dsa_out_if rsp_bus ();

  descriptor_slot_allocator_core #(
    .SLOTS(SLOTS),
    .HANDLE_BITS(FH_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  slot_kind_t      slot_kind [SLOTS];
  logic [FH_W-1:0] slot_fh [SLOTS];
  logic            slot_ce [SLOTS];
  int unsigned     free_hint;

  outcome_t pending_outcomes [$];
  int       error_count = 0;
  int       stalled_cycles = 0;
  int       hold_cycles_request = 0;
  bit       idle_enabled = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // table predictor
  function automatic int claim_lowest_free(int unsigned min_slot);
    int unsigned from;
    bit          from_hint;
    from = (min_slot >= free_hint) ? min_slot : free_hint;
    from_hint = (from == free_hint);
    for (int unsigned s = from; s < SLOTS; s++) begin
      if (slot_kind[s] == SLOT_FREE) begin
        slot_kind[s] = SLOT_RESERVED;
        if (from_hint) free_hint = s + 1;
        return int'(s);
      end
    end
    if (from_hint && free_hint < SLOTS) free_hint = SLOTS;
    return -1;
  endfunction

  function automatic outcome_t apply_request(op_t op, logic [IDX_W-1:0] idx,
                                             logic [ARG_W-1:0] arg, logic [FH_W-1:0] fh,
                                             logic ce);
    outcome_t   res;
    bit         in_table;
    slot_kind_t kind;
    int         got;
    res.status = STAT_OK;
    res.slot = idx;
    res.handle = '0;
    res.flag = 1'b0;
    in_table = idx < SLOTS;
    kind = in_table ? slot_kind[idx] : SLOT_FREE;
    case (op)
      OP_ALLOC: begin
        got = claim_lowest_free(arg);
        if (got < 0) res.status = STAT_NO_SLOT;
        else res.slot = got[IDX_W-1:0];
      end
      OP_BIND: begin
        if (!in_table || kind != SLOT_RESERVED) res.status = STAT_BAD_DESC;
        else begin
          slot_kind[idx] = SLOT_BOUND;
          slot_fh[idx] = fh;
          slot_ce[idx] = ce;
        end
      end
      OP_RELEASE: begin
        if (!in_table || kind == SLOT_FREE) res.status = STAT_BAD_DESC;
        else begin
          slot_kind[idx] = SLOT_FREE;
          slot_ce[idx] = 1'b0;
          if (idx < free_hint) free_hint = idx;
        end
      end
      OP_LOOKUP: begin
        if (!in_table || kind != SLOT_BOUND) res.status = STAT_BAD_DESC;
        else res.handle = slot_fh[idx];
      end
      OP_INSTALL: begin
        if (!in_table || kind == SLOT_RESERVED) res.status = STAT_BAD_DESC;
        else begin
          slot_kind[idx] = SLOT_BOUND;
          slot_fh[idx] = fh;
          slot_ce[idx] = ce;
          if (free_hint == idx) free_hint++;
        end
      end
      OP_GET_FLAG: begin
        if (!in_table || kind != SLOT_BOUND) res.status = STAT_BAD_DESC;
        else res.flag = slot_ce[idx];
      end
      OP_SET_FLAG: begin
        if (!in_table || kind != SLOT_BOUND) res.status = STAT_BAD_DESC;
        else slot_ce[idx] = arg[0];
      end
      default: begin
        if (!in_table || kind != SLOT_BOUND) res.status = STAT_BAD_DESC;
        else begin
          got = claim_lowest_free(arg);
          if (got < 0) res.status = STAT_NO_SLOT;
          else begin
            slot_kind[got] = SLOT_BOUND;
            slot_fh[got] = slot_fh[idx];
            slot_ce[got] = ce;
            res.slot = got[IDX_W-1:0];
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic int find_slot(bit [2:0] kinds);
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++)
      if (kinds[slot_kind[(start + k) % SLOTS]]) return (start + k) % SLOTS;
    return -1;
  endfunction

  function automatic int pick_minimum();
    case ($urandom_range(0, 7))
      0, 1, 2, 3: return 0;
      4, 5:       return $urandom_range(0, SLOTS - 1);
      6:          return free_hint;
      default:    return $urandom_range(0, 1023);
    endcase
  endfunction

  task automatic send_request(op_t op, int idx, int arg, logic [FH_W-1:0] fh, logic ce);
    outcome_t want;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.mode        <= op;
    req_bus.slot_index  <= idx[IDX_W-1:0];
    req_bus.argument    <= arg[ARG_W-1:0];
    req_bus.file_handle <= fh;
    req_bus.cloexec     <= ce;
    want = apply_request(op, idx[IDX_W-1:0], arg[ARG_W-1:0], fh, ce);
    do @(posedge clk); while (!req_bus.ready);
    pending_outcomes.push_back(want);
  endtask

  task automatic send_random_request(int unsigned release_odds);
    int  pick;
    int  s;
    int  idx;
    int  arg;
    op_t op;
    s = -1;
    pick = $urandom_range(0, 99);
    idx = $urandom_range(0, SLOTS - 1);
    arg = pick_minimum();
    if (pick < 8) begin
      op = op_t'($urandom_range(0, 7));
      idx = $urandom_range(0, 1023);
      arg = $urandom_range(0, 1023);
    end else if (pick < 8 + release_odds) begin
      op = OP_RELEASE;
      s = find_slot(WANT_IN_USE);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 22) op = OP_ALLOC;
      else if (pick < 40) begin
        op = OP_BIND;
        s = find_slot(WANT_RESERVED);
      end else if (pick < 52) begin
        op = OP_LOOKUP;
        s = find_slot(WANT_BOUND);
      end else if (pick < 62) op = OP_INSTALL;
      else if (pick < 72) begin
        op = OP_GET_FLAG;
        s = find_slot(WANT_BOUND);
      end else if (pick < 82) begin
        op = OP_SET_FLAG;
        s = find_slot(WANT_BOUND);
        arg = $urandom_range(0, 1023);
      end else begin
        op = OP_DUP;
        s = find_slot(WANT_BOUND);
      end
    end
    if (s >= 0) idx = s;
    send_request(op, idx, arg, FH_W'($urandom), 1'($urandom));
  endtask

  task automatic wait_for_outcomes();
    req_bus.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_request(OP_LOOKUP,   0,    0,      16'h0000, 1'b0);
    send_request(OP_ALLOC,    0,    0,      16'h0000, 1'b0);
    send_request(OP_BIND,     0,    10'h3FF, 16'hFFFF, 1'b1);
    send_request(OP_LOOKUP,   0,    0,      16'h0000, 1'b0);
    send_request(OP_GET_FLAG, 0,    0,      16'h0000, 1'b0);
    send_request(OP_SET_FLAG, 0,    10'h3FE, 16'h0000, 1'b0);
    send_request(OP_GET_FLAG, 0,    0,      16'h0000, 1'b0);
    send_request(OP_DUP,      0,    63,     16'h0000, 1'b1);
    send_request(OP_LOOKUP,   63,   0,      16'h0000, 1'b0);
    send_request(OP_ALLOC,    0,    1023,   16'h0000, 1'b0);
    send_request(OP_INSTALL,  1023, 0,      16'hAAAA, 1'b1);
    send_request(OP_RELEASE,  64,   0,      16'h0000, 1'b0);
    send_request(OP_INSTALL,  1,    0,      16'h0000, 1'b0);
    send_request(OP_ALLOC,    0,    5,      16'h0000, 1'b0);
    send_request(OP_INSTALL,  5,    0,      16'h5555, 1'b1);
    send_request(OP_BIND,     5,    0,      16'h1234, 1'b0);
    send_request(OP_ALLOC,    0,    0,      16'h0000, 1'b0);
    send_request(OP_RELEASE,  2,    0,      16'h0000, 1'b0);
    send_request(OP_RELEASE,  0,    0,      16'h0000, 1'b0);
    send_request(OP_RELEASE,  0,    0,      16'h0000, 1'b0);
    send_request(OP_DUP,      0,    0,      16'h0000, 1'b1);
    send_request(OP_BIND,     3,    0,      16'h0F0F, 1'b1);
    send_request(OP_SET_FLAG, 0,    1,      16'h0000, 1'b0);
    send_request(OP_GET_FLAG, 700,  0,      16'h0000, 1'b0);
  endtask

  task automatic test_output_backpressure();
    hold_cycles_request = HOLD_OFF_CYCLES;
    for (int n = 0; n < 40; n++) send_random_request(15);
    wait_for_outcomes();
  endtask

  task automatic test_table_exhaustion();
    send_request(OP_RELEASE, 0, 0, FH_W'($urandom), 1'b0);
    for (int s = SLOTS - 1; s >= 0; s--)
      send_request(slot_kind[s] == SLOT_RESERVED ? OP_BIND : OP_INSTALL, s, pick_minimum(),
                   FH_W'($urandom), 1'($urandom));
    send_request(OP_ALLOC,   0,  0,    FH_W'($urandom), 1'b0);
    send_request(OP_ALLOC,   0,  3,    FH_W'($urandom), 1'b0);
    send_request(OP_DUP,     5,  0,    FH_W'($urandom), 1'b1);
    send_request(OP_ALLOC,   0,  1023, FH_W'($urandom), 1'b0);
    send_request(OP_RELEASE, 20, 0,    FH_W'($urandom), 1'b0);
    send_request(OP_ALLOC,   0,  30,   FH_W'($urandom), 1'b0);
    send_request(OP_ALLOC,   0,  0,    FH_W'($urandom), 1'b0);
    send_request(OP_BIND,    20, 0,    FH_W'($urandom), 1'b1);
  endtask

  task automatic test_random_traffic(int count);
    int unsigned release_odds;
    release_odds = 10;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) release_odds = $urandom_range(4, 30);
      if (n == count - QUIET_TAIL) idle_enabled = 1'b0;
      send_random_request(release_odds);
    end
  endtask

  // response side ready, with random stalls and one long hold-off on request
  initial begin : sink_ready
    int n;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles_request > 0) begin
        n = hold_cycles_request;
        hold_cycles_request = 0;
        rsp_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_bus.ready <= 1'b1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
        rsp_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with nothing outstanding: slot %0d", rsp_bus.result_slot);
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          error_count++;
        end
        if (rsp_bus.result_slot !== want.slot) begin
          $error("result_slot: expected %0d, got %0d", want.slot, rsp_bus.result_slot);
          error_count++;
        end
        if (rsp_bus.handle_out !== want.handle) begin
          $error("handle_out: expected %h, got %h", want.handle, rsp_bus.handle_out);
          error_count++;
        end
        if (rsp_bus.flag_out !== want.flag) begin
          $error("flag_out: expected %0d, got %0d", want.flag, rsp_bus.flag_out);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
      stalled_cycles <= 0;
    else
      stalled_cycles <= stalled_cycles + 1;
  end

  initial begin : watchdog
    while (stalled_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    req_bus.valid       <= 1'b0;
    req_bus.mode        <= OP_ALLOC;
    req_bus.slot_index  <= '0;
    req_bus.argument    <= '0;
    req_bus.file_handle <= '0;
    req_bus.cloexec     <= 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      slot_kind[s] = SLOT_FREE;
      slot_fh[s] = '0;
      slot_ce[s] = 1'b0;
    end
    free_hint = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_backpressure();
    test_table_exhaustion();
    test_random_traffic(RANDOM_OPS);
    wait_for_outcomes();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
